FILE: hw/rtl/htdr_pkg.sv
// Shared types, field widths and helper functions for the hash table block.
// No dependencies; imported by every module of the block.
package htdr_pkg;

  localparam int KEY_W       = 64;
  localparam int IN_MOVE_W   = 16;
  localparam int DEPTH_W     = 8;
  localparam int IN_VALUE_W  = 16;
  localparam int BOUND_W     = 2;
  localparam int AGE_W       = 8;
  localparam int SCORE_W     = 11;

  // The modulo unit folds this many key bits into the remainder each cycle.
  localparam int STEP_BITS   = 4;

  localparam int IN_DATA_W   = 112;
  localparam int OUT_DATA_W  = 56;

  typedef enum logic [1:0] {
    ACT_STORE      = 2'd0,
    ACT_PROBE      = 2'd1,
    ACT_NEW_SEARCH = 2'd2,
    ACT_CLEAR      = 2'd3
  } action_t;

  localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd0;

  typedef struct packed {
    logic                         hit;
    logic                         written;
    logic [IN_MOVE_W-1:0]         move;
    logic signed [DEPTH_W-1:0]    depth;
    logic signed [IN_VALUE_W-1:0] value;
    logic [BOUND_W-1:0]           bound;
    logic [AGE_W-1:0]             age;
  } result_t;

  // Replacement priority: a current generation outranks an exact bound,
  // which outranks depth.
  function automatic logic signed [SCORE_W-1:0] entry_score(
    input logic                      exact,
    input logic                      age_match,
    input logic signed [DEPTH_W-1:0] depth
  );
    logic signed [SCORE_W-1:0] base;
    base = signed'(SCORE_W'({age_match, exact, 7'b0}));
    return base + SCORE_W'(depth);
  endfunction

endpackage

FILE: hw/rtl/htdr_index.sv
// Table index unit: key modulo the entry count.
// Depends on htdr_pkg. A power-of-two count takes the low key bits, registered
// with done in the cycle after start; any other count runs a restoring remainder, STEP_BITS bits a cycle.
module htdr_index import htdr_pkg::*; #(
  parameter int ENTRY_COUNT = 65536,
  parameter int IDX_W       = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [IDX_W-1:0] index
);

  localparam bit IS_POW2 = (ENTRY_COUNT & (ENTRY_COUNT - 1)) == 0;

  generate
    if (IS_POW2) begin : g_pow2
      always_ff @(posedge clk) begin
        if (rst) begin
          done <= 1'b0;
        end else begin
          done <= start;
        end
        if (start) begin
          index <= key[IDX_W-1:0];
        end
      end
    end else begin : g_mod
      localparam int STEPS     = KEY_W / STEP_BITS;
      localparam int STEP_CNT_W = $clog2(STEPS);
      localparam logic [IDX_W:0] DIVISOR = (IDX_W + 1)'(ENTRY_COUNT);

      logic                  busy;
      logic [STEP_CNT_W-1:0] step_cnt;
      logic [KEY_W-1:0]      shift;
      logic [IDX_W-1:0]      rem_step;

      always_comb begin
        logic [IDX_W:0]   t;
        logic [IDX_W-1:0] r;
        r = index;
        t = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
          t = {r, shift[KEY_W-1-i]};
          if (t >= DIVISOR) begin
            t = t - DIVISOR;
          end
          r = t[IDX_W-1:0];
        end
        rem_step = r;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          busy <= 1'b0;
          done <= 1'b0;
        end else begin
          done <= 1'b0;
          if (start) begin
            busy <= 1'b1;
          end else if (busy && step_cnt == STEP_CNT_W'(STEPS - 1)) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
        if (start) begin
          shift    <= key;
          index    <= '0;
          step_cnt <= '0;
        end else if (busy) begin
          shift    <= shift << STEP_BITS;
          index    <= rem_step;
          step_cnt <= step_cnt + 1'b1;
        end
      end
    end
  endgenerate

endmodule

FILE: hw/rtl/htdr_mem.sv
// Entry memory: one write port and one read port with registered read data.
// Depends on htdr_pkg only for the common import style.
module htdr_mem import htdr_pkg::*; #(
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16,
  parameter int WIDTH  = 114
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/hash_table_with_depth_replacement_top.sv
// Store/probe: the key is registered, the index unit finds the row (for a
// non-power-of-two ENTRY_COUNT the modulo unit runs 16 steps), the memory is
// read and the update state writes the entry (store) and loads the result; one
// item is in work at a time, so the next input transfer waits until that result
// is loaded. New search: the generation steps on and the finish state loads the
// result. Clear: one memory row per cycle, then the finish state loads the result.
// Reset runs the same clearing pass (s_axis_tready low) and zeroes the
// generation. Depends on htdr_pkg, htdr_index, htdr_mem.
module hash_table_with_depth_replacement_top import htdr_pkg::*; #(
  parameter int ENTRY_COUNT = 65536,
  parameter int MOVE_BITS   = 16,
  parameter int VALUE_BITS  = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // hash_key[63:0], best_move[79:64], search_depth[87:80], eval_value[103:88],
  // bound_kind[105:104], zero fill
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // action[1:0]
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // found_move[15:0], found_depth[23:16], found_value[39:24], found_bound[41:40],
  // found_age[49:42], zero fill
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // hit[0], written[1]
  output logic [1:0]            m_axis_tuser
);

  localparam int IDX_W = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

  typedef struct packed {
    logic [KEY_W-1:0]      key;
    logic [MOVE_BITS-1:0]  move;
    logic [DEPTH_W-1:0]    depth;
    logic [VALUE_BITS-1:0] value;
    logic [BOUND_W-1:0]    bound;
    logic [AGE_W-1:0]      age;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_INDEX  = 6'b000010,
    S_READ   = 6'b000100,
    S_UPDATE = 6'b001000,
    S_CLEAR  = 6'b010000,
    S_FINISH = 6'b100000
  } state_t;

  state_t                       state;
  logic [AGE_W-1:0]             age;
  logic [IDX_W-1:0]             clear_cnt;
  logic                         clear_reply;
  logic                         idx_start;

  action_t                      item_action;
  logic [KEY_W-1:0]             item_key;
  logic [IN_MOVE_W-1:0]         item_move;
  logic signed [DEPTH_W-1:0]    item_depth;
  logic signed [IN_VALUE_W-1:0] item_value;
  logic [BOUND_W-1:0]           item_bound;

  logic                         out_valid;
  result_t                      out_result;
  result_t                      result_next;

  logic                         in_xfer;
  logic                         out_free;
  logic                         clear_last;
  logic                         idx_done;
  logic [IDX_W-1:0]             idx;
  logic [ENTRY_W-1:0]           rd_data;
  entry_t                       old_entry;
  entry_t                       new_entry;
  logic signed [VALUE_BITS-1:0] old_value;
  logic                         new_exact;
  logic                         old_exact;
  logic                         key_same;
  logic                         keep_old;
  logic                         replace;
  logic                         is_store;
  logic                         load_out;
  logic                         wr_en;
  logic [IDX_W-1:0]             wr_addr;
  logic [ENTRY_W-1:0]           wr_data;

  assign s_axis_tready = (state == S_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid || m_axis_tready;
  assign clear_last    = (clear_cnt == IDX_W'(ENTRY_COUNT - 1));

  htdr_index #(
    .ENTRY_COUNT(ENTRY_COUNT),
    .IDX_W      (IDX_W)
  ) u_index (
    .clk  (clk),
    .rst  (rst),
    .start(idx_start),
    .key  (item_key),
    .done (idx_done),
    .index(idx)
  );

  htdr_mem #(
    .DEPTH (ENTRY_COUNT),
    .ADDR_W(IDX_W),
    .WIDTH (ENTRY_W)
  ) u_mem (
    .clk    (clk),
    .rd_en  (state == S_READ),
    .rd_addr(idx),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

  // Entry update and result for store and probe.
  always_comb begin
    old_entry = entry_t'(rd_data);
    old_value = old_entry.value;
    is_store  = (item_action == ACT_STORE);
    new_exact = (item_bound == BOUND_EXACT);
    old_exact = (old_entry.bound == BOUND_EXACT);
    key_same  = (old_entry.key == item_key);

    new_entry.key   = item_key;
    new_entry.move  = MOVE_BITS'(item_move);
    new_entry.depth = item_depth;
    new_entry.value = VALUE_BITS'(item_value);
    new_entry.bound = item_bound;
    new_entry.age   = age;

    // A shallower result for the same position never displaces a resident one
    // of the same exactness.
    keep_old = key_same && (new_exact == old_exact)
               && (item_depth < signed'(old_entry.depth));
    replace  = (entry_score(new_exact, 1'b1, item_depth)
                >= entry_score(old_exact, old_entry.age == age,
                               signed'(old_entry.depth)))
               && !keep_old;

    result_next = '0;
    if (state == S_UPDATE) begin
      if (is_store) begin
        result_next.written = replace;
      end else if (key_same) begin
        result_next.hit   = 1'b1;
        result_next.move  = IN_MOVE_W'(old_entry.move);
        result_next.depth = old_entry.depth;
        result_next.value = IN_VALUE_W'(old_value);
        result_next.bound = old_entry.bound;
        result_next.age   = old_entry.age;
      end
    end

    load_out = out_free && (state == S_UPDATE || state == S_FINISH);
    wr_en    = (state == S_CLEAR) || (state == S_UPDATE && out_free && is_store && replace);
    wr_addr  = (state == S_CLEAR) ? clear_cnt : idx;
    wr_data  = (state == S_CLEAR) ? '0 : new_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      age         <= '0;
      clear_cnt   <= '0;
      clear_reply <= 1'b0;
      idx_start   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      // The index unit starts in the cycle after the transfer, once the key is registered.
      idx_start <= in_xfer && (action_t'(s_axis_tuser) == ACT_STORE
                               || action_t'(s_axis_tuser) == ACT_PROBE);
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            unique case (action_t'(s_axis_tuser))
              ACT_STORE, ACT_PROBE: state <= S_INDEX;
              ACT_NEW_SEARCH: begin
                age   <= (age == {AGE_W{1'b1}}) ? AGE_W'(1) : age + 1'b1;
                state <= S_FINISH;
              end
              ACT_CLEAR: begin
                clear_cnt   <= '0;
                clear_reply <= 1'b1;
                state       <= S_CLEAR;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_INDEX: begin
          if (idx_done) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_UPDATE;
        end
        S_UPDATE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        S_CLEAR: begin
          clear_cnt <= clear_cnt + 1'b1;
          if (clear_last) begin
            state <= clear_reply ? S_FINISH : S_IDLE;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_action <= action_t'(s_axis_tuser);
      item_key    <= s_axis_tdata[63:0];
      item_move   <= s_axis_tdata[79:64];
      item_depth  <= s_axis_tdata[87:80];
      item_value  <= s_axis_tdata[103:88];
      item_bound  <= s_axis_tdata[105:104];
    end
    if (load_out) begin
      out_result <= result_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = {out_result.written, out_result.hit};
  assign m_axis_tdata  = {6'b0, out_result.age, out_result.bound, out_result.value,
                          out_result.depth, out_result.move};

  a_write_states: assert property (@(posedge clk)
    wr_en |-> (state == S_CLEAR || state == S_UPDATE))
    else $error("memory write outside clear or update");

  a_index_done: assert property (@(posedge clk) disable iff (rst)
    idx_done |-> state == S_INDEX)
    else $error("index unit finished outside index wait");

  a_hit_written: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("result flags both hit and written");

  a_age_nonzero: assert property (@(posedge clk) disable iff (rst)
    age != '0 |=> age != '0)
    else $error("generation returned to zero");

  a_clear_ends: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR && clear_last |=> state != S_CLEAR)
    else $error("clearing pass ran past the last row");

endmodule
